/* rtl/deq_pkg.sv */
// deq_pkg: opcodes and transfer structs for the double-ended queue unit
// no dependencies; imported by the queue top level
package deq_pkg;

  // operation codes carried in the command opcode field
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } deq_op_t;

  // word reported for front and back when the queue holds nothing
  localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

  // one command transfer
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } deq_cmd_t;

  // one result transfer
  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               is_full;
    logic               overflow;
  } deq_result_t;

endpackage

/* rtl/deq_ram.sv */
// deq_ram: generic single-write, single-read synchronous RAM
// read data registered; no package dependency
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port (read during write returns old data)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/double_ended_queue_unit.sv */
// Bounded double-ended queue of signed 32-bit words held in a ring buffer of
// DEPTH entries. A command is taken on any cycle with start high (busy stays
// low), so one command per cycle is sustained; its result appears on result
// with done high exactly one cycle later, and must be captured then since
// the receiver cannot stall it. The latency is set by the registered read of
// the two storage RAMs, one read at the front position and one at the back.
// A push on a full queue is dropped and flagged as overflow; a pop on an
// empty queue is ignored. Front and back read all ones when empty.
// Depends on deq_pkg and deq_ram.
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  deq_pkg::deq_cmd_t    cmd,
  output logic                 done,
  output deq_pkg::deq_result_t result
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // ring position and occupancy
  logic [AW-1:0] front_index, front_next;
  logic [CW-1:0] stored_count, count_next;

  // storage port controls
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] back_addr;
  logic [31:0]   front_rdata, back_rdata;

  // registered result bookkeeping
  logic              fwd_front, fwd_back, ovf_q;
  logic [CW-1:0]     count_q;
  logic signed [31:0] fwd_value;

  logic          accept;
  logic          full_now;
  logic          ovf;
  logic [AW-1:0] tail_addr;
  logic [CW:0]   back_sum;

  // reduce a sum below twice the depth to a ring position
  function automatic logic [AW-1:0] wrap_pos(input logic [CW:0] s);
    logic [CW:0] t;
    t = (s >= (CW+1)'(DEPTH)) ? s - (CW+1)'(DEPTH) : s;
    return t[AW-1:0];
  endfunction

  assign busy     = 1'b0;
  assign accept   = start;
  assign full_now = (stored_count == CW'(DEPTH));
  assign tail_addr = wrap_pos({{(CW+1-AW){1'b0}}, front_index} + {1'b0, stored_count});

  // next position, next count and the storage write
  always_comb begin
    front_next = front_index;
    count_next = stored_count;
    we         = 1'b0;
    waddr      = tail_addr;
    ovf        = 1'b0;
    if (accept) begin
      case (cmd.opcode)
        OP_PUSH_FRONT: begin
          if (full_now) begin
            ovf = 1'b1;
          end else begin
            front_next = (front_index == '0) ? AW'(DEPTH - 1) : front_index - 1'b1;
            we         = 1'b1;
            waddr      = front_next;
            count_next = stored_count + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full_now) begin
            ovf = 1'b1;
          end else begin
            we         = 1'b1;
            waddr      = tail_addr;
            count_next = stored_count + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (stored_count != '0) begin
            front_next = wrap_pos({{(CW+1-AW){1'b0}}, front_index} + (CW+1)'(1));
            count_next = stored_count - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (stored_count != '0) begin
            count_next = stored_count - 1'b1;
          end
        end
        default: begin
          front_next = front_index;
        end
      endcase
    end
  end

  // back position after the command
  assign back_sum  = {{(CW+1-AW){1'b0}}, front_next} + {1'b0, count_next};
  assign back_addr = (count_next == '0) ? front_next : wrap_pos(back_sum - (CW+1)'(1));

  // position and occupancy registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index  <= '0;
      stored_count <= '0;
      done         <= 1'b0;
    end else begin
      front_index  <= front_next;
      stored_count <= count_next;
      done         <= accept;
    end
  end

  // result side registers; a same-cycle write bypasses the old read data
  always_ff @(posedge clk) begin
    if (accept) begin
      count_q   <= count_next;
      ovf_q     <= ovf;
      fwd_value <= cmd.push_value;
      fwd_front <= we && (waddr == front_next);
      fwd_back  <= we && (waddr == back_addr);
    end
  end

  // two copies of the ring, one read at the front and one at the back
  deq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_front_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cmd.push_value),
    .raddr(front_next),
    .rdata(front_rdata)
  );

  deq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_back_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cmd.push_value),
    .raddr(back_addr),
    .rdata(back_rdata)
  );

  // assemble the result transfer
  always_comb begin
    result.entry_count = 5'(count_q);
    result.is_empty    = (count_q == '0);
    result.is_full     = (count_q == CW'(DEPTH));
    result.overflow    = ovf_q;
    if (count_q == '0) begin
      result.front_value = EMPTY_WORD;
      result.back_value  = EMPTY_WORD;
    end else begin
      result.front_value = fwd_front ? fwd_value : front_rdata;
      result.back_value  = fwd_back ? fwd_value : back_rdata;
    end
  end

endmodule
